// ===== hdl/vic_pkg.sv =====
// Package for the vectored interrupt controller: widths, register map codes,
// request codes and identification bytes. No dependencies.
package vic_pkg;
  localparam int LEVELS      = 17;
  localparam int DATA_W      = 32;
  localparam int OFF_W       = 12;
  localparam int PRIO_W      = 5;
  localparam int DEF_SOURCES = 32;
  localparam int DEF_VECTORS = 16;

  typedef enum logic [1:0] {
    REQ_LINE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [9:0] W_IRQSTAT  = 10'd0;
  localparam logic [9:0] W_FIQSTAT  = 10'd1;
  localparam logic [9:0] W_RAWSTAT  = 10'd2;
  localparam logic [9:0] W_FIQSEL   = 10'd3;
  localparam logic [9:0] W_ENABLE   = 10'd4;
  localparam logic [9:0] W_ENCLR    = 10'd5;
  localparam logic [9:0] W_SOFT     = 10'd6;
  localparam logic [9:0] W_SOFTCLR  = 10'd7;
  localparam logic [9:0] W_PROT     = 10'd8;
  localparam logic [9:0] W_RSVD     = 10'd11;
  localparam logic [9:0] W_VECTADDR = 10'd12;
  localparam logic [9:0] W_DEFVECT  = 10'd13;
  localparam logic [9:0] W_TESTCTRL = 10'hc0;

  function automatic logic [7:0] id_byte(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0: b = 8'h90;
      3'd1: b = 8'h11;
      3'd2: b = 8'h04;
      3'd3: b = 8'h00;
      3'd4: b = 8'h0d;
      3'd5: b = 8'hf0;
      3'd6: b = 8'h05;
      default: b = 8'h81;
    endcase
    return b;
  endfunction

  function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] sz);
    logic [DATA_W-1:0] m;
    case (sz)
      2'd0: m = 32'h0000_00ff;
      2'd1: m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction
endpackage

// ===== hdl/vic_if.sv =====
// Channel interfaces for the vectored interrupt controller.
// Depends on vic_pkg.
interface vic_req_if;
  import vic_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [OFF_W-1:0]  reg_offset;
  logic [1:0]        access_size;
  logic [DATA_W-1:0] write_data;
  logic [4:0]        line_index;
  logic              line_level;
  modport source (output valid, req_type, reg_offset, access_size, write_data,
                  line_index, line_level, input ready);
  modport sink (input valid, req_type, reg_offset, access_size, write_data,
                line_index, line_level, output ready);
endinterface

interface vic_rsp_if;
  import vic_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              access_error;
  logic              irq_out;
  logic              fiq_out;
  modport source (output valid, read_data, access_error, irq_out, fiq_out,
                  input ready);
  modport sink (input valid, read_data, access_error, irq_out, fiq_out,
                output ready);
endinterface

interface vic_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/vic_prio.sv =====
// Priority search over the vector slots: highest pending level below the
// current priority. Depends on vic_pkg.
module vic_prio #(
  parameter int NUM_VECTORS = vic_pkg::DEF_VECTORS
) (
  input  logic [31:0]                        pend,
  input  logic [NUM_VECTORS-1:0][7:0]        vctl,
  input  logic [vic_pkg::PRIO_W-1:0]         cur_prio,
  output logic                               found,
  output logic [vic_pkg::PRIO_W-1:0]         level
);
  import vic_pkg::*;

  logic [15:0] hit;       // slot i enabled and its source pending
  logic [15:0][31:0] src; // one-hot source claimed by slot i

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      src[i] = '0;
      if (i < NUM_VECTORS) begin
        if (vctl[i][5]) src[i][vctl[i][4:0]] = 1'b1;
      end
      hit[i] = |(src[i] & pend);
    end
  end

  // level i < cur_prio wins if slot i is the lowest such slot with a pending
  // source; else level 16 < cur_prio if any source is pending (it claims all)
  always_comb begin
    found = 1'b0;
    level = PRIO_W'(LEVELS);
    if (cur_prio > PRIO_W'(16) && pend != '0) begin
      found = 1'b1;
      level = PRIO_W'(16);
    end
    for (int i = 15; i >= 0; i--) begin
      if (PRIO_W'(i) < cur_prio && hit[i]) begin
        found = 1'b1;
        level = PRIO_W'(i);
      end
    end
  end
endmodule

// ===== hdl/vectored_interrupt_controller_unit.sv =====
// Vectored interrupt controller: one request transaction (line change,
// register read or write) gives one response transaction. Depends on
// vic_pkg, vic_if and vic_prio.
//
// For each transaction the request is decoded, state updated
// and the response registered in the same cycle, through a flat 17-level
// priority encoder. A new request is taken every cycle while the response
// register is empty or being drained. cfg holds chained mode.
module vectored_interrupt_controller_unit #(
  parameter int NUM_SOURCES = vic_pkg::DEF_SOURCES,
  parameter int NUM_VECTORS = vic_pkg::DEF_VECTORS
) (
  input  logic      clk,
  input  logic      rst,
  vic_req_if.sink   req,
  vic_rsp_if.source rsp,
  vic_cfg_if.sink   cfg
);
  import vic_pkg::*;

  localparam logic [31:0] SRC_BITS = 32'hffff_ffff >> (32 - NUM_SOURCES);

  logic              chained;
  logic [31:0]       raw_level, sw_level, int_en, fiq_sel;
  logic [31:0]       raw_level_next, sw_level_next, int_en_next, fiq_sel_next;
  logic [NUM_VECTORS-1:0][31:0] vaddr;
  logic [NUM_VECTORS-1:0][7:0]  vctl, vctl_next;
  logic [31:0]       def_vect;
  logic [PRIO_W-1:0] cur_prio, cur_prio_next;
  logic [LEVELS-1:0][PRIO_W-1:0] prio_stack;
  logic              prot;

  logic              rsp_valid;
  logic [31:0]       rsp_data;
  logic              rsp_err, rsp_irq, rsp_fiq;

  logic        take;
  logic [31:0] pend, pend_next, msk, wdata, rd, stat_next;
  logic        err, do_wr, vread, vwrite;
  logic [9:0]  word;
  logic        in_va, in_vc, in_id;
  logic [5:0]  slot;
  logic        slot_ok;
  logic        found, irq_n, fiq_n;
  logic [PRIO_W-1:0] level;

  assign req.ready = !rsp_valid || rsp.ready;
  assign cfg.ready = 1'b1;
  assign take      = req.valid && req.ready;

  assign rsp.valid        = rsp_valid;
  assign rsp.read_data    = rsp_data;
  assign rsp.access_error = rsp_err;
  assign rsp.irq_out      = rsp_irq;
  assign rsp.fiq_out      = rsp_fiq;

  assign pend  = (raw_level | sw_level) & SRC_BITS;
  assign msk   = size_mask(req.access_size);
  assign wdata = req.write_data & msk;
  assign word  = req.reg_offset[11:2];
  assign in_id = req.reg_offset >= 12'hfe0;
  assign in_va = req.reg_offset[11:6] == 6'h04;
  assign in_vc = req.reg_offset[11:6] == 6'h08;
  assign slot  = {2'b00, req.reg_offset[5:2]};
  assign slot_ok = slot < 6'(NUM_VECTORS);

  vic_prio #(.NUM_VECTORS(NUM_VECTORS)) u_prio (
    .pend(pend), .vctl(vctl), .cur_prio(cur_prio),
    .found(found), .level(level)
  );

  // decode: read data, error, and whether a write is applied
  always_comb begin
    rd = '0; err = 1'b0; do_wr = 1'b0; vread = 1'b0; vwrite = 1'b0;
    if (req.req_type == REQ_READ) begin
      if (in_id) rd = {24'd0, id_byte(req.reg_offset[4:2])};
      else if (in_va) begin
        if (slot_ok) rd = vaddr[slot[3:0]];
      end else if (in_vc) begin
        if (slot_ok) rd = {24'd0, vctl[slot[3:0]]};
      end else begin
        case (word)
          W_IRQSTAT:  rd = pend & int_en & ~fiq_sel;
          W_FIQSTAT:  rd = pend & fiq_sel;
          W_RAWSTAT:  rd = pend;
          W_FIQSEL:   rd = fiq_sel;
          W_ENABLE:   rd = int_en;
          W_SOFT:     rd = sw_level;
          W_PROT:     rd = {31'd0, prot};
          W_RSVD:     rd = '0;
          W_VECTADDR: begin
            vread = 1'b1;
            // nothing new above the active level: that level's vector again
            if (!found) begin
              if (cur_prio < PRIO_W'(16)) rd = vaddr[cur_prio[3:0]];
              else rd = def_vect;
            end else if (level == PRIO_W'(16)) rd = def_vect;
            else rd = vaddr[level[3:0]];
          end
          W_DEFVECT:  rd = def_vect;
          default:    err = 1'b1;
        endcase
      end
      rd = rd & msk;
    end else if (req.req_type == REQ_WRITE) begin
      if (in_va || in_vc) do_wr = 1'b1;
      else begin
        case (word)
          W_IRQSTAT, W_RSVD: ;
          W_FIQSEL, W_ENABLE, W_ENCLR, W_SOFT, W_SOFTCLR, W_PROT, W_DEFVECT:
            do_wr = 1'b1;
          W_VECTADDR: vwrite = 1'b1;
          W_TESTCTRL: err = wdata != '0;
          default:    err = 1'b1;
        endcase
      end
    end
  end

  always_comb begin
    raw_level_next = raw_level;
    sw_level_next  = sw_level;
    int_en_next    = int_en;
    fiq_sel_next   = fiq_sel;
    cur_prio_next  = cur_prio;
    vctl_next      = vctl;
    if (req.req_type == REQ_LINE && 32'(req.line_index) < 32'(NUM_SOURCES))
      raw_level_next[req.line_index] = req.line_level;
    if (do_wr && in_vc && slot_ok) vctl_next[slot[3:0]] = wdata[7:0];
    if (do_wr && !in_va && !in_vc) begin
      case (word)
        W_FIQSEL:  fiq_sel_next = wdata & SRC_BITS;
        W_ENABLE:  int_en_next = int_en | (wdata & SRC_BITS);
        W_ENCLR:   int_en_next = int_en & ~(wdata & SRC_BITS);
        W_SOFT:    sw_level_next = sw_level | (wdata & SRC_BITS);
        W_SOFTCLR: sw_level_next = sw_level & ~(wdata & SRC_BITS);
        default: ;
      endcase
    end
    if (vread && found && level < cur_prio) cur_prio_next = level;
    if (vwrite && cur_prio < PRIO_W'(LEVELS)) begin
      if (prio_stack[cur_prio] > PRIO_W'(LEVELS)) cur_prio_next = '0;
      else cur_prio_next = prio_stack[cur_prio];
    end
  end

  assign pend_next = (raw_level_next | sw_level_next) & SRC_BITS;
  assign stat_next = pend_next & int_en_next & ~fiq_sel_next;

  // irq sees the priority and slot controls as they stand after this item
  logic [31:0] mask_used;
  always_comb begin
    mask_used = '0;
    if (cur_prio_next >= PRIO_W'(LEVELS)) mask_used = '1;
    else begin
      for (int i = 0; i < 16; i++) begin
        if (i < NUM_VECTORS && PRIO_W'(i) < cur_prio_next && vctl_next[i][5])
          mask_used[vctl_next[i][4:0]] = 1'b1;
      end
    end
  end

  assign irq_n = chained ? (stat_next != '0) : ((stat_next & mask_used) != '0);
  assign fiq_n = chained ? 1'b0 : ((pend_next & fiq_sel_next) != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      chained <= 1'b0; raw_level <= '0; sw_level <= '0;
      int_en <= '0; fiq_sel <= '0; vaddr <= '0; vctl <= '0;
      def_vect <= '0; cur_prio <= PRIO_W'(LEVELS); prio_stack <= '0;
      prot <= 1'b0; rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) chained <= cfg.data;
      rsp_valid <= take || (rsp_valid && !rsp.ready);
      if (take) begin
        raw_level <= raw_level_next;
        sw_level  <= sw_level_next;
        int_en    <= int_en_next;
        fiq_sel   <= fiq_sel_next;
        cur_prio  <= cur_prio_next;
        vctl      <= vctl_next;
        if (vread && found && level < cur_prio) prio_stack[level] <= cur_prio;
        if (do_wr && in_va && slot_ok) vaddr[slot[3:0]] <= wdata;
        if (do_wr && !in_va && !in_vc && word == W_PROT) prot <= wdata[0];
        if (do_wr && !in_va && !in_vc && word == W_DEFVECT) def_vect <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_data <= rd; rsp_err <= err; rsp_irq <= irq_n; rsp_fiq <= fiq_n;
    end
  end

`ifndef SYNTHESIS
  a_prio_range: assert property (@(posedge clk) disable iff (rst)
    cur_prio <= PRIO_W'(LEVELS)) else $error("priority out of range");
  a_chain_fiq: assert property (@(posedge clk) disable iff (rst)
    take && chained |=> !rsp_fiq)
    else $error("fiq in chained mode");
  a_line_no_err: assert property (@(posedge clk) disable iff (rst)
    take && req.req_type == REQ_LINE |=> !rsp_err) else $error("line error");
  a_push_lowers: assert property (@(posedge clk) disable iff (rst)
    take && vread |=> cur_prio <= $past(cur_prio)) else $error("push raised");
`endif
endmodule
